// ----- design/rsas_pkg.sv -----
// Package for the rotated sorted array search block.
// Shared field widths, operation codes and the result type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsas_pkg;

    localparam int VALUE_IN_W = 32;
    localparam int POS_W      = 10;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } res_t;

endpackage

`default_nettype wire

// ----- design/rsas_if.sv -----
// Valid/ready channel interfaces for the request and result sides.
// Depends on rsas_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rsas_req_if import rsas_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic                         first;
    logic signed [VALUE_IN_W-1:0] value;

    modport source (output valid, operation, first, value, input ready);
    modport sink   (input valid, operation, first, value, output ready);
endinterface

interface rsas_res_if import rsas_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

// ----- design/rsas_engine.sv -----
// Element memory, element count and the rotation-aware binary search sequencer.
// Depends on rsas_pkg and the rsas_req_if interface.
`timescale 1ns / 1ps
`default_nettype none

module rsas_engine import rsas_pkg::*; #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rsas_req_if.sink   request,
    output logic       res_valid,
    input  wire logic  res_ready,
    output res_t       res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_A0   = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_MID  = 3'd3;
    localparam logic [2:0] ST_RGT  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    logic [2:0]                    state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic signed [CW:0]            l_reg, l_next;
    logic signed [CW:0]            r_reg, r_next;
    logic signed [CW:0]            m_reg, m_next;
    logic signed [VALUE_WIDTH-1:0] t_reg, t_next;
    logic signed [VALUE_WIDTH-1:0] a0_reg, a0_next;
    logic signed [VALUE_WIDTH-1:0] am_reg, am_next;
    logic                          hit_reg, hit_next;
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;

    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [CW-1:0]                 load_idx;
    logic signed [63:0]            val_ext;
    logic signed [VALUE_WIDTH-1:0] val_w;
    logic signed [CW:0]            span;
    logic                          accept;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;

    // 32-bit field sign-extended, then cut to the stored width
    assign val_ext  = 64'(request.value);
    assign val_w    = val_ext[VALUE_WIDTH-1:0];
    assign load_idx = request.first ? '0 : count_reg;
    assign wr_en    = accept && (request.operation == OP_LOAD) && (load_idx < DEPTH_C);
    assign wr_addr  = load_idx[AW-1:0];
    assign span     = r_reg - l_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_w;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        m_next     = m_reg;
        t_next     = t_reg;
        a0_next    = a0_reg;
        am_next    = am_reg;
        hit_next   = hit_reg;
        rd_en      = 1'b0;
        rd_addr    = m_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.operation == OP_LOAD)
                    begin
                        if (load_idx < DEPTH_C)
                        begin
                            count_next = load_idx + 1'b1;
                        end
                    end
                    else
                    begin
                        t_next   = val_w;
                        hit_next = 1'b0;
                        m_next   = '0;
                        l_next   = '0;
                        r_next   = (CW+1)'($signed({1'b0, count_reg}) - 1);
                        if (count_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_A0;
                        end
                    end
                end
            end
            ST_A0:
            begin
                a0_next    = rd_data_reg;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (l_reg <= r_reg)
                begin
                    m_next     = l_reg + (span >>> 1);
                    rd_en      = 1'b1;
                    rd_addr    = m_next[AW-1:0];
                    state_next = ST_MID;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MID:
            begin
                am_next = rd_data_reg;
                if (rd_data_reg == t_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (rd_data_reg >= a0_reg)
                begin
                    // left part sorted
                    if (rd_data_reg > t_reg && a0_reg <= t_reg)
                    begin
                        r_next = m_reg - 2'sd1;
                    end
                    else
                    begin
                        l_next = m_reg + 2'sd1;
                    end
                    state_next = ST_STEP;
                end
                else
                begin
                    // right part sorted, need the element at r
                    rd_en      = 1'b1;
                    rd_addr    = r_reg[AW-1:0];
                    state_next = ST_RGT;
                end
            end
            ST_RGT:
            begin
                if (t_reg <= rd_data_reg && t_reg > am_reg)
                begin
                    l_next = m_reg + 2'sd1;
                end
                else
                begin
                    r_next = m_reg - 2'sd1;
                end
                state_next = ST_STEP;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        m_reg   <= m_next;
        t_reg   <= t_next;
        a0_reg  <= a0_next;
        am_reg  <= am_next;
        hit_reg <= hit_next;
    end

    assign res_valid    = (state_reg == ST_DONE);
    assign res.found    = hit_reg;
    assign res.position = hit_reg ? POS_W'(m_reg) : '0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("element count above depth");

    a_count_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("element count changed during a search");

    a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MID) |->
            (m_reg >= l_reg && m_reg <= r_reg && m_reg < $signed({1'b0, count_reg})))
        else $error("midpoint outside search window");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (state_reg == ST_IDLE))
        else $error("result transfer did not return to idle");
`endif

endmodule

`default_nettype wire

// ----- design/rotated_sorted_array_search.sv -----
// Rotated sorted array search, top level. A load transfer (operation 0) appends
// one element and gives no result; first restarts the array at index zero, and
// loads past DEPTH are dropped. A search transfer (operation 1) runs a binary
// search over the stored elements that adapts to the rotation and returns one
// result: found and the match index (low 10 bits), zero on a miss. A search
// first fetches element 0, then each halving step reads the middle element and,
// when the right part is sorted, also the element at r, as the element memory
// has a single read port. An empty array answers without a memory read. A result
// waits in an output register, so the next request is taken while it is still
// pending. Depends on rsas_pkg, rsas_if, rsas_engine.
`timescale 1ns / 1ps
`default_nettype none

module rotated_sorted_array_search import rsas_pkg::*; #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rsas_req_if.sink   request,
    rsas_res_if.source result
);

    logic res_valid;
    logic res_ready;
    res_t res;
    logic out_valid_reg, out_valid_next;
    res_t out_reg;

    rsas_engine #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.found    = out_reg.found;
    assign result.position = out_reg.position;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.found) |-> (result.position == '0))
        else $error("miss reported with nonzero position");

    a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> out_valid_reg)
        else $error("result transfer lost at output register");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result changed before transfer");
`endif

endmodule

`default_nettype wire
